@@ rtl/wpaa_pkg.sv @@
// Package for the weighted polygon area accumulator.
// Holds widths, side codes, weight selection and term scaling; no dependencies.
package wpaa_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned TERM_W  = PROD_W + 3;

  localparam logic [1:0] SIDE_ON  = 2'b00;
  localparam logic [1:0] SIDE_IN  = 2'b01;
  localparam logic [1:0] SIDE_BAD = 2'b10;
  localparam logic [1:0] SIDE_OUT = 2'b11;

  typedef logic signed [2:0] weight_t;

  typedef struct packed {
    weight_t wq;
    weight_t wm;
    weight_t wj;
  } weights_t;

  typedef struct packed {
    logic en;
    logic clr;
  } acc_ctrl_t;

  // Doubled weights chosen by the side codes at the two ends of a segment.
  function automatic weights_t seg_weights(logic [1:0] prev, logic [1:0] cur);
    weights_t w;
    w = '0;
    if (prev != SIDE_BAD && cur != SIDE_BAD) begin
      case ({prev, cur}) inside
        {SIDE_IN, SIDE_IN}, {SIDE_IN, SIDE_ON}, {SIDE_ON, SIDE_IN}: begin
          w.wq = -3'sd2;
          w.wm = 3'sd2;
          w.wj = 3'sd0;
        end
        {SIDE_IN, SIDE_OUT}, {SIDE_ON, SIDE_ON}, {SIDE_OUT, SIDE_IN}: begin
          w.wq = 3'sd0;
          w.wm = 3'sd1;
          w.wj = 3'sd1;
        end
        default: begin
          w.wq = 3'sd2;
          w.wm = 3'sd0;
          w.wj = 3'sd2;
        end
      endcase
    end
    return w;
  endfunction

  function automatic logic signed [TERM_W-1:0] scale_term(weight_t w,
                                                         logic signed [TERM_W-1:0] t);
    logic signed [TERM_W-1:0] r;
    case (w)
      3'sd1:   r = t;
      3'sd2:   r = t <<< 1;
      -3'sd2:  r = -(t <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wpaa_acc.sv @@
// One saturating 64-bit area accumulator with clear on the final segment.
// Depends on wpaa_pkg.
module wpaa_acc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wpaa_pkg::acc_ctrl_t                   ctrl_i,
  input  logic signed [wpaa_pkg::TERM_W-1:0]    term_i,
  output logic signed [wpaa_pkg::ACC_W-1:0]     sum_o
);
  import wpaa_pkg::*;

  logic signed [ACC_W-1:0] sum_q, sum_d;
  logic signed [ACC_W:0]   wide;

  always_comb begin
    wide = $signed({sum_q[ACC_W-1], sum_q})
         + $signed({{(ACC_W + 1 - TERM_W){term_i[TERM_W-1]}}, term_i});
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sum_o = wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sum_o = wide[ACC_W-1:0];
    end
    sum_d = ctrl_i.clr ? '0 : sum_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.en) begin
      sum_q <= sum_d;
    end
  end

endmodule

@@ rtl/weighted_polygon_area_accumulator.sv @@
// Weighted polygon area accumulator: shoelace sums over a streamed polyline.
// Depends on wpaa_pkg and wpaa_acc.
// A final vertex passes stages s1 and s2 before its sums are captured in the output registers.
// Throughput: one vertex per cycle; a request waits only while a result is
// stalled at the output and another final vertex reaches the accumulators.
// Reset clears the previous vertex, the accumulator sums, the error flag and all valids.
module weighted_polygon_area_accumulator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [wpaa_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [wpaa_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [1:0]                     side_code_i,
  input  logic                                  final_vertex_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [wpaa_pkg::ACC_W-1:0]     plain_sum_o,
  output logic signed [wpaa_pkg::ACC_W-1:0]     q_sum_o,
  output logic signed [wpaa_pkg::ACC_W-1:0]     meet_sum_o,
  output logic signed [wpaa_pkg::ACC_W-1:0]     join_sum_o,
  output logic                                  bad_code_o
);
  import wpaa_pkg::*;

  typedef struct packed {
    logic                     seg;
    logic                     last;
    logic                     bad;
    weights_t                 w;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
  } s1_t;

  typedef struct packed {
    logic                     last;
    logic                     bad;
    logic signed [TERM_W-1:0] t_plain;
    logic signed [TERM_W-1:0] t_q;
    logic signed [TERM_W-1:0] t_m;
    logic signed [TERM_W-1:0] t_j;
  } s2_t;

  logic                      in_acc, hold;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [1:0]                prev_side_q;
  logic                      have_prev_q;
  logic                      s1_valid_q, s2_valid_q;
  s1_t                       s1_q, s1_d;
  s2_t                       s2_q, s2_d;
  logic signed [PROD_W:0]    diff;
  logic signed [TERM_W-1:0]  t_seg;
  acc_ctrl_t                 acc_ctrl;
  logic signed [ACC_W-1:0]   plain_nx, q_nx, meet_nx, join_nx;
  logic                      err_q, err_nx;
  logic                      out_valid_q;
  logic signed [ACC_W-1:0]   plain_q, q_q, meet_q, join_q;
  logic                      bad_q;

  assign hold       = s2_valid_q && s2_q.last && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_d.seg  = have_prev_q;
    s1_d.last = final_vertex_i;
    s1_d.bad  = (side_code_i == SIDE_BAD);
    s1_d.w    = seg_weights(prev_side_q, side_code_i);
    s1_d.pa   = pos_x_i * prev_y_q;
    s1_d.pb   = prev_x_q * pos_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_side_q <= SIDE_ON;
      have_prev_q <= 1'b0;
    end else if (in_acc) begin
      prev_x_q    <= pos_x_i;
      prev_y_q    <= pos_y_i;
      prev_side_q <= side_code_i;
      have_prev_q <= !final_vertex_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!hold) begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (!hold && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // T = (y0+y1)(x1-x0) - (x0+x1)(y1-y0) reduces to 2(x1*y0 - x0*y1).
  always_comb begin
    diff  = $signed({s1_q.pa[PROD_W-1], s1_q.pa}) - $signed({s1_q.pb[PROD_W-1], s1_q.pb});
    t_seg = s1_q.seg ? ($signed({{2{diff[PROD_W]}}, diff}) <<< 1) : '0;
    s2_d.last    = s1_q.last;
    s2_d.bad     = s1_q.bad;
    s2_d.t_plain = t_seg <<< 1;
    s2_d.t_q     = scale_term(s1_q.w.wq, t_seg);
    s2_d.t_m     = scale_term(s1_q.w.wm, t_seg);
    s2_d.t_j     = scale_term(s1_q.w.wj, t_seg);
  end

  assign acc_ctrl.en  = s2_valid_q && !hold;
  assign acc_ctrl.clr = s2_q.last;

  wpaa_acc u_acc_plain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (s2_q.t_plain),
    .sum_o  (plain_nx)
  );

  wpaa_acc u_acc_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (s2_q.t_q),
    .sum_o  (q_nx)
  );

  wpaa_acc u_acc_meet (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (s2_q.t_m),
    .sum_o  (meet_nx)
  );

  wpaa_acc u_acc_join (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (s2_q.t_j),
    .sum_o  (join_nx)
  );

  assign err_nx = err_q || s2_q.bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (acc_ctrl.en) begin
      err_q <= acc_ctrl.clr ? 1'b0 : err_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_ctrl.en && acc_ctrl.clr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_ctrl.en && acc_ctrl.clr) begin
      plain_q <= plain_nx;
      q_q     <= q_nx;
      meet_q  <= meet_nx;
      join_q  <= join_nx;
      bad_q   <= err_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign plain_sum_o = plain_q;
  assign q_sum_o     = q_q;
  assign meet_sum_o  = meet_q;
  assign join_sum_o  = join_q;
  assign bad_code_o  = bad_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ctrl.en && acc_ctrl.clr |=> out_valid_o)
    else $error("final segment did not produce a result");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s2_valid_q && s2_q.last))
    else $error("result appeared without a final vertex");

  a_final_clears_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_vertex_i |=> !have_prev_q)
    else $error("previous vertex kept across curves");

endmodule
